// ----- rtl/core/kns_pkg.sv -----
// Shared types, constants and table functions for the Kepler Newton solver.
`default_nettype none
package kns_pkg;
    localparam int ANGLE_WIDTH_DEF  = 32;
    localparam int CORDIC_STEPS_DEF = 30;
    localparam int TOL_W            = 29;
    localparam int LIM_W            = 7;
    localparam int ECC_W            = 16;
    localparam int IO_ANGLE_W       = 32;
    localparam int IO_FRAC          = 28;
    localparam int LIMIT_MAX        = 64;
    localparam logic [0:0] REG_TOLERANCE = 1'b0;
    localparam logic [0:0] REG_LIMIT     = 1'b1;
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_REDUCE = 4'd2,
        OP_CSTEP  = 4'd3,
        OP_FORM   = 4'd4,
        OP_MULT   = 4'd5,
        OP_DIVST  = 4'd6,
        OP_DSTEP  = 4'd7,
        OP_UPDATE = 4'd8
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic reduce_done;
        logic cordic_done;
        logic div_done;
        logic met;
    } dp_sts_t;

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic logic signed [63:0] q60_to_f(input logic [63:0] v, input int fb);
        int s;
        logic [63:0] r;
        s = 60 - fb;
        r = (v + (64'd1 << (s - 1))) >> s;
        return $signed(r);
    endfunction

    function automatic logic signed [63:0] pi_f(input int fb);
        return q60_to_f(PI_Q60, fb);
    endfunction

    function automatic logic signed [63:0] half_pi_f(input int fb);
        return q60_to_f(PI_Q60 >> 1, fb);
    endfunction

    function automatic logic signed [63:0] two_pi_f(input int fb);
        return q60_to_f(PI_Q60 << 1, fb);
    endfunction

    function automatic logic signed [63:0] atan_f(input int i, input int fb);
        logic [63:0] acc;
        logic [63:0] term;
        int s;
        acc = 64'd0;
        if (i == 0) begin
            acc = PI_Q60 >> 2;
        end else begin
            for (int k = 0; k < 64; k++) begin
                s = 60 - i * (2 * k + 1);
                if (s >= 0) begin
                    term = (64'd1 << s) / 64'(2 * k + 1);
                    acc = k[0] ? acc - term : acc + term;
                end
            end
        end
        return q60_to_f(acc, fb);
    endfunction

    function automatic logic signed [63:0] gain_f(input int steps, input int fb);
        logic [63:0] g2;
        logic [63:0] y;
        logic [63:0] t;
        g2 = 64'd1 << 60;
        y  = 64'd5 << 57;
        for (int i = 0; i < steps; i++) begin
            if (2 * i < 64) g2 = g2 + (g2 >> (2 * i));
        end
        for (int i = 0; i < 8; i++) begin
            t = mul_q60(g2, mul_q60(y, y));
            y = mul_q60(y, (64'd3 << 60) - t) >> 1;
        end
        return q60_to_f(y, fb);
    endfunction
endpackage
`default_nettype wire

// ----- rtl/core/kns_datapath.sv -----
// Datapath: range reduction, serial CORDIC, Newton residual, serial divider, update.
`default_nettype none
module kns_datapath #(
    parameter int ANGLE_WIDTH  = kns_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = kns_pkg::CORDIC_STEPS_DEF
) (
    input  wire                                  aclk,
    input  wire kns_pkg::dp_cmd_t                cmd,
    input  wire signed [kns_pkg::IO_ANGLE_W-1:0] mean_anomaly,
    input  wire [kns_pkg::ECC_W-1:0]             eccentricity,
    input  wire [kns_pkg::TOL_W-1:0]             tolerance,
    output kns_pkg::dp_sts_t                     sts,
    output logic signed [kns_pkg::IO_ANGLE_W-1:0] result_angle
);
    localparam int F   = ANGLE_WIDTH - 4;
    localparam int W   = ANGLE_WIDTH + 2;   // working width with headroom for reduction and CORDIC
    localparam int NW  = ANGLE_WIDTH + 4;   // residual width
    localparam int QW  = F + 5;             // quotient width, one bit above the clamp
    localparam int SW  = $clog2(CORDIC_STEPS + 1);
    localparam int BW  = $clog2(F + 4);
    localparam int UP  = F - kns_pkg::IO_FRAC;
    localparam int TW  = QW + ((UP < 0) ? -UP : 0) + 1;
    localparam logic signed [W-1:0] PI_C   = W'(kns_pkg::pi_f(F));
    localparam logic signed [W-1:0] HPI_C  = W'(kns_pkg::half_pi_f(F));
    localparam logic signed [W-1:0] TPI_C  = W'(kns_pkg::two_pi_f(F));
    localparam logic signed [W-1:0] GAIN_C = W'(kns_pkg::gain_f(CORDIC_STEPS, F));
    localparam logic signed [W-1:0] E_HI   = W'((64'sd8 <<< F) - 1);
    localparam logic signed [W-1:0] E_LO   = W'(-(64'sd8 <<< F));
    localparam logic [QW-1:0]       Q_LIM  = QW'((65'd1 << (F + 4)) - 1);

    logic signed [W-1:0]  e_reg, e_next, m_reg, m_next;
    logic signed [W-1:0]  z_reg, z_next, x_reg, x_next, y_reg, y_next;
    logic                 flip_reg, flip_next;
    logic [SW-1:0]        i_reg, i_next;
    logic [kns_pkg::ECC_W-1:0] ecc_reg, ecc_next;
    logic signed [NW-1:0] num_reg, num_next;
    logic [NW-1:0]        den_reg, den_next, rem_reg, rem_next;
    logic [QW-1:0]        q_reg, q_next;
    logic                 neg_reg, neg_next, ddone_reg, ddone_next;
    logic [BW-1:0]        b_reg, b_next;
    logic signed [W+kns_pkg::ECC_W:0] ps_reg, ps_next, pc_reg, pc_next;

    logic signed [W-1:0] atan_v, xs, ys;
    logic [NW-1:0]       trial;

    always_comb begin
        atan_v = '0;
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            if (i_reg == SW'(k)) atan_v = W'(kns_pkg::atan_f(k, F));
        end
    end

    assign xs    = x_reg >>> i_reg;
    assign ys    = y_reg >>> i_reg;
    // remainder stays below den < 2^(F+2), so its top bit is free
    assign trial = {rem_reg[NW-2:0], num_reg[NW-1]};

    logic signed [W-1:0]  e_sub;
    logic signed [NW-1:0] f_v, d_v, est_s;
    logic [TW-1:0]        mag_c, tol_c;
    assign est_s = NW'(e_reg);
    assign f_v = est_s - NW'(ps_reg >>> kns_pkg::ECC_W) - NW'(m_reg);
    assign d_v = (NW'(1) <<< F) - NW'(pc_reg >>> kns_pkg::ECC_W);

    logic signed [NW:0] e_upd;
    assign e_upd = {e_reg[W-1], NW'(e_reg)} -
                   (neg_reg ? -$signed({1'b0, NW'(q_reg)}) : $signed({1'b0, NW'(q_reg)}));

    always_comb begin
        if (UP >= 0) begin
            mag_c = TW'(q_reg);
            tol_c = TW'({{TW{1'b0}}, tolerance} << UP);
        end else begin
            mag_c = TW'({{TW{1'b0}}, q_reg} << (-UP));
            tol_c = TW'(tolerance);
        end
    end

    always_comb begin
        e_next = e_reg; m_next = m_reg; z_next = z_reg; x_next = x_reg; y_next = y_reg;
        flip_next = flip_reg; i_next = i_reg; ecc_next = ecc_reg; num_next = num_reg;
        den_next = den_reg; rem_next = rem_reg; q_next = q_reg; neg_next = neg_reg;
        b_next = b_reg; ps_next = ps_reg; pc_next = pc_reg; ddone_next = ddone_reg;
        e_sub = '0;
        unique case (cmd.op)
            kns_pkg::OP_LOAD: begin
                e_next = '0;
                ecc_next = eccentricity;
                i_next = '0; ddone_next = 1'b0;
                if (UP >= 0) m_next = W'(mean_anomaly) <<< UP;
                else         m_next = W'(mean_anomaly >>> (-UP));
            end
            kns_pkg::OP_REDUCE: begin
                // one 2*pi or pi fold per cycle; start value held in z
                if (i_reg == '0) begin
                    z_next = e_reg; i_next = SW'(1); flip_next = 1'b0;
                end else if (z_reg > PI_C) begin
                    z_next = z_reg - TPI_C;
                end else if (z_reg < -PI_C) begin
                    z_next = z_reg + TPI_C;
                end else if (z_reg > HPI_C) begin
                    z_next = z_reg - PI_C; flip_next = 1'b1;
                end else if (z_reg < -HPI_C) begin
                    z_next = z_reg + PI_C; flip_next = 1'b1;
                end
                x_next = GAIN_C; y_next = '0;
            end
            kns_pkg::OP_CSTEP: begin
                if (!ddone_reg) begin
                    // first cycle: restart the stage counter
                    i_next = '0; ddone_next = 1'b1;
                end else if (i_reg != SW'(CORDIC_STEPS)) begin
                    if (!z_reg[W-1]) begin
                        x_next = x_reg - ys; y_next = y_reg + xs; z_next = z_reg - atan_v;
                    end else begin
                        x_next = x_reg + ys; y_next = y_reg - xs; z_next = z_reg + atan_v;
                    end
                    i_next = i_reg + SW'(1);
                end
            end
            kns_pkg::OP_MULT: begin
                e_sub = flip_reg ? -y_reg : y_reg;
                ps_next = e_sub * $signed({1'b0, ecc_reg});
                pc_next = (flip_reg ? -x_reg : x_reg) * $signed({1'b0, ecc_reg});
                i_next = '0; ddone_next = 1'b0;
            end
            kns_pkg::OP_FORM: begin
                num_next = f_v[NW-1] ? -f_v : f_v;
                neg_next = f_v[NW-1];
                den_next = (d_v < NW'(1)) ? NW'(1) : NW'(d_v);
            end
            kns_pkg::OP_DIVST: begin
                // a quotient of 2^(F+4) or more (num >= 16*den) only saturates
                q_next = '0; b_next = '0;
                if ($unsigned(num_reg) >= (den_reg << 4)) begin
                    q_next = Q_LIM; ddone_next = 1'b1;
                end else begin
                    rem_next = $unsigned(num_reg) >> 4;
                    num_next = num_reg <<< (NW - 4);
                    ddone_next = 1'b0;
                end
            end
            kns_pkg::OP_DSTEP: begin
                // restoring division, one quotient bit per cycle over F+4 bits
                if (!ddone_reg) begin
                    if (trial >= den_reg) begin
                        rem_next = trial - den_reg;
                        q_next = {q_reg[QW-2:0], 1'b1};
                    end else begin
                        rem_next = trial;
                        q_next = {q_reg[QW-2:0], 1'b0};
                    end
                    num_next = num_reg <<< 1;
                    b_next = b_reg + BW'(1);
                    if (b_reg == BW'(F + 3)) ddone_next = 1'b1;
                end
            end
            kns_pkg::OP_UPDATE: begin
                if (e_upd > (NW+1)'(E_HI))      e_next = E_HI;
                else if (e_upd < (NW+1)'(E_LO)) e_next = E_LO;
                else                              e_next = W'(e_upd);
                i_next = '0; ddone_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        e_reg <= e_next; m_reg <= m_next; z_reg <= z_next; x_reg <= x_next; y_reg <= y_next;
        flip_reg <= flip_next; i_reg <= i_next; ecc_reg <= ecc_next; num_reg <= num_next;
        den_reg <= den_next; rem_reg <= rem_next; q_reg <= q_next; neg_reg <= neg_next;
        b_reg <= b_next; ps_reg <= ps_next; pc_reg <= pc_next; ddone_reg <= ddone_next;
    end

    assign sts.reduce_done = (i_reg != '0) && !(z_reg > PI_C) && !(z_reg < -PI_C)
                             && !(z_reg > HPI_C) && !(z_reg < -HPI_C);
    assign sts.cordic_done = ddone_reg && (i_reg == SW'(CORDIC_STEPS));
    assign sts.div_done    = ddone_reg;
    assign sts.met         = mag_c < tol_c;

    always_comb begin
        if (UP >= 0) result_angle = kns_pkg::IO_ANGLE_W'(e_reg >>> UP);
        else         result_angle = kns_pkg::IO_ANGLE_W'(e_reg <<< (-UP));
    end
endmodule
`default_nettype wire

// ----- rtl/core/kns_ctrl.sv -----
// Controller: sequences the load, then per Newton step reduction, CORDIC, products, residual, division and update.
`default_nettype none
module kns_ctrl (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           in_fire,
    input  wire                           out_free,
    input  wire [kns_pkg::LIM_W-1:0]      limit,
    input  wire kns_pkg::dp_sts_t         sts,
    output kns_pkg::dp_cmd_t              cmd,
    output logic                          busy,
    output logic                          done,
    output logic [kns_pkg::LIM_W-1:0]     used,
    output logic                          conv
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_REDUCE = 8'b00000010,
        S_CORDIC = 8'b00000100,
        S_MULT   = 8'b00001000,
        S_FORM   = 8'b00010000,
        S_DIV    = 8'b00100000,
        S_UPDATE = 8'b01000000,
        S_DONE   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [kns_pkg::LIM_W-1:0] n_reg, n_next, lim_reg, lim_next;
    logic conv_reg, conv_next, dstart_reg, dstart_next;

    always_comb begin
        state_next = state_reg; n_next = n_reg; lim_next = lim_reg; conv_next = conv_reg;
        dstart_next = 1'b0;
        cmd.op = kns_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.op = kns_pkg::OP_LOAD;
                    n_next = '0; conv_next = 1'b0;
                    lim_next = (limit > kns_pkg::LIM_W'(kns_pkg::LIMIT_MAX)) ?
                               kns_pkg::LIM_W'(kns_pkg::LIMIT_MAX) : limit;
                    state_next = (lim_next == '0) ? S_DONE : S_REDUCE;
                end
            end
            S_REDUCE: begin
                cmd.op = kns_pkg::OP_REDUCE;
                if (sts.reduce_done) state_next = S_CORDIC;
            end
            S_CORDIC: begin
                cmd.op = kns_pkg::OP_CSTEP;
                if (sts.cordic_done) state_next = S_MULT;
            end
            S_MULT: begin
                cmd.op = kns_pkg::OP_MULT;
                state_next = S_FORM;
            end
            S_FORM: begin
                cmd.op = kns_pkg::OP_FORM;
                state_next = S_DIV; dstart_next = 1'b1;
            end
            S_DIV: begin
                cmd.op = dstart_reg ? kns_pkg::OP_DIVST : kns_pkg::OP_DSTEP;
                if (!dstart_reg && sts.div_done) state_next = S_UPDATE;
            end
            S_UPDATE: begin
                cmd.op = kns_pkg::OP_UPDATE;
                n_next = n_reg + kns_pkg::LIM_W'(1);
                if (sts.met) begin
                    conv_next = 1'b1; state_next = S_DONE;
                end else if (n_next == lim_reg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_REDUCE;
                end
            end
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; n_reg <= '0; lim_reg <= '0; conv_reg <= 1'b0;
            dstart_reg <= 1'b0;
        end else begin
            state_reg <= state_next; n_reg <= n_next; lim_reg <= lim_next;
            conv_reg <= conv_next; dstart_reg <= dstart_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE) && out_free;
    assign used = n_reg;
    assign conv = conv_reg;
endmodule
`default_nettype wire

// ----- rtl/core/kepler_newton_solver.sv -----
// Top level: stream ports, configuration registers, result register.
//  channel   | dir | tdata / fields (low bit up)
//  s_axis    | in  | tdata: mean_anomaly[31:0], eccentricity[47:32]
//  m_axis    | out | tdata: eccentric_anomaly[31:0], iterations_used[38:32], converged[39]
//  cfg       | in  | cfg_index (0 tolerance, 1 limit), cfg_data
// One item at a time. Each Newton step: range-reduction folds, the CORDIC steps, the products
// and residual, the serial divider (cut short when the correction saturates), one update;
// an item takes that for each step used, plus a load and the hand-off of its result.
// Reset clears control and restores register defaults; a waiting result holds on stall.
`default_nettype none
module kepler_newton_solver #(
    parameter int ANGLE_WIDTH  = kns_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = kns_pkg::CORDIC_STEPS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // mean_anomaly, eccentricity
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // eccentric_anomaly, iterations_used, converged
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [0:0]  cfg_index,
    input  wire  [28:0] cfg_data
);
    logic [kns_pkg::TOL_W-1:0] tol_reg, tol_next;
    logic [kns_pkg::LIM_W-1:0] lim_reg, lim_next;
    logic        busy, done, conv, in_fire, mvalid_reg, mvalid_next;
    logic [kns_pkg::LIM_W-1:0] used;
    logic [39:0] mdata_reg, mdata_next;
    logic signed [kns_pkg::IO_ANGLE_W-1:0] angle;
    kns_pkg::dp_cmd_t cmd;
    kns_pkg::dp_sts_t sts;

    assign s_tready  = !busy;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        tol_next = tol_reg; lim_next = lim_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                kns_pkg::REG_TOLERANCE: tol_next = cfg_data;
                kns_pkg::REG_LIMIT:     lim_next = cfg_data[kns_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next = mdata_reg;
        if (done) begin
            mvalid_next = 1'b1;
            mdata_next = {conv, used, angle};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= kns_pkg::TOL_W'(26844); lim_reg <= kns_pkg::LIM_W'(32);
            mvalid_reg <= 1'b0;
        end else begin
            tol_reg <= tol_next; lim_reg <= lim_next; mvalid_reg <= mvalid_next;
        end
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    kns_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire),
        .out_free(!mvalid_reg || m_tready), .limit(lim_reg), .sts(sts),
        .cmd(cmd), .busy(busy), .done(done), .used(used), .conv(conv)
    );

    kns_datapath #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .aclk(aclk), .cmd(cmd), .mean_anomaly(s_tdata[31:0]),
        .eccentricity(s_tdata[47:32]), .tolerance(tol_reg), .sts(sts),
        .result_angle(angle)
    );

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> busy) else $error("accepted item did not start work");
    a_done_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> m_tvalid) else $error("finished result not presented");
    a_iter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[38:32] <= 7'd64) else $error("iteration count over cap");
endmodule
`default_nettype wire

// ----- tb/kns_scoreboard.sv -----
// Checker for the Kepler solver: tracks register writes, predicts each solution, compares.
`timescale 1ns / 1ps
module kns_scoreboard (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [47:0] s_tdata,   // mean_anomaly, eccentricity
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [39:0] m_tdata,   // eccentric_anomaly, iterations_used, converged
    input  wire         cfg_valid,
    input  wire         cfg_ready,
    input  wire  [0:0]  cfg_index,
    input  wire  [28:0] cfg_data,
    output int          fail_count,
    output int          open_solutions
);
    localparam int FRAC   = 28;
    localparam int NSTAGE = 30;

    // first member lands in the top bits, matching the result beat layout
    typedef struct packed {
        logic               conv;
        logic [6:0]         steps;
        logic signed [31:0] anomaly;
    } solution_t;

    solution_t   solution_q[$];
    logic [28:0] tol_reg;
    logic [6:0]  limit_reg;

    longint atan_lut[NSTAGE];
    longint k_pi, k_half_pi, k_two_pi, k_gain;

    function automatic longint to_frac(input logic [63:0] v);
        logic [63:0] r;
        r = (v + (64'd1 << (60 - FRAC - 1))) >> (60 - FRAC);
        return longint'(r);
    endfunction

    function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = 128'(a) * 128'(b);
        return prod[123:60];
    endfunction

    initial begin
        logic [63:0] acc, g2, y;
        g2 = 64'd1 << 60;
        y  = 64'd5 << 57;
        k_pi      = to_frac(kns_pkg::PI_Q60);
        k_half_pi = to_frac(kns_pkg::PI_Q60 >> 1);
        k_two_pi  = to_frac(kns_pkg::PI_Q60 << 1);
        for (int i = 0; i < NSTAGE; i++) begin
            acc = 0;
            if (i == 0) acc = kns_pkg::PI_Q60 >> 2;
            else begin
                // arctan(2^-i) power series in Q60
                for (int k = 0; 60 - i * (2 * k + 1) >= 0; k++) begin
                    if (k % 2 == 1) acc = acc - (64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1);
                    else            acc = acc + (64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1);
                end
            end
            atan_lut[i] = to_frac(acc);
            g2 = g2 + (g2 >> (2 * i));
        end
        // inverse square root of the gain product by Newton iteration
        for (int i = 0; i < 8; i++)
            y = q60_mul(y, (64'd3 << 60) - q60_mul(g2, q60_mul(y, y))) >> 1;
        k_gain = to_frac(y);
    end

    function automatic longint newton_correction(input longint est, input longint m,
                                                 input longint ecc);
        longint z, x, yv, nx, sn, cs, f, den;
        logic [63:0] num, q, r, d, lim;
        logic flip;
        z = est; x = k_gain; yv = 0; flip = 0;
        lim = (64'd1 << (FRAC + 4)) - 1;
        while (z > k_pi) z -= k_two_pi;
        while (z < -k_pi) z += k_two_pi;
        if (z > k_half_pi) begin
            z -= k_pi; flip = 1;
        end else if (z < -k_half_pi) begin
            z += k_pi; flip = 1;
        end
        for (int i = 0; i < NSTAGE; i++) begin
            if (z >= 0) begin
                nx = x - (yv >>> i); yv = yv + (x >>> i); z -= atan_lut[i];
            end else begin
                nx = x + (yv >>> i); yv = yv - (x >>> i); z += atan_lut[i];
            end
            x = nx;
        end
        sn = flip ? -yv : yv;
        cs = flip ? -x : x;
        f   = est - ((ecc * sn) >>> 16) - m;
        den = (64'sd1 <<< FRAC) - ((ecc * cs) >>> 16);
        if (den < 1) den = 1;
        d   = den;
        num = f < 0 ? -f : f;
        q   = num / d;
        if (q > lim) q = lim;
        else begin
            r = num % d;
            for (int b = 0; b < FRAC; b++) begin
                r = r << 1; q = q << 1;
                if (r >= d) begin
                    r = r - d; q[0] = 1'b1;
                end
                if (q > lim) begin
                    q = lim; break;
                end
            end
        end
        return f < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic solution_t solve_kepler(input logic [47:0] beat);
        longint m, ecc, est, dl, mag;
        int limit;
        solution_t s;
        m = longint'($signed(beat[31:0]));
        ecc = longint'(beat[47:32]);
        est = 0;
        limit = limit_reg > kns_pkg::LIMIT_MAX ? kns_pkg::LIMIT_MAX : limit_reg;
        s = '0;
        for (int n = 1; n <= limit; n++) begin
            dl  = newton_correction(est, m, ecc);
            est = est - dl;
            if (est > (64'sd8 <<< FRAC) - 1) est = (64'sd8 <<< FRAC) - 1;
            if (est < -(64'sd8 <<< FRAC)) est = -(64'sd8 <<< FRAC);
            s.steps = 7'(n);
            mag = dl < 0 ? -dl : dl;
            if (mag < longint'(tol_reg)) begin
                s.conv = 1'b1; break;
            end
        end
        s.anomaly = est[31:0];
        return s;
    endfunction

    always @(posedge aclk) begin
        solution_t exp_s, got;
        if (!aresetn) begin
            tol_reg        <= 29'd26844;
            limit_reg      <= 7'd32;
            fail_count     <= 0;
            open_solutions <= 0;
            solution_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == kns_pkg::REG_TOLERANCE) tol_reg <= cfg_data;
                else limit_reg <= cfg_data[6:0];
            end
            if (s_tvalid && s_tready) solution_q.push_back(solve_kepler(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (solution_q.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result beat %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_s = solution_q.pop_front();
                    if (got != exp_s) begin
                        if (fail_count < 10)
                            $display("mismatch exp/got: E %h/%h steps %0d/%0d conv %b/%b",
                                     exp_s.anomaly, got.anomaly, exp_s.steps, got.steps,
                                     exp_s.conv, got.conv);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            open_solutions <= solution_q.size();
        end
    end
endmodule

// ----- tb/tb_top.sv -----
// Testbench top: clock, reset, stimulus and register writes for the Kepler solver.
`timescale 1ns / 1ps
module tb_top;
    localparam int STALL_LIMIT = 60000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = kns_pkg::REG_TOLERANCE;
    logic [28:0] cfg_data = '0;
    int          fail_count, open_solutions;
    int          burst_left = 0;
    int          quiet_cycles = 0;
    logic        stimulus_done = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    kepler_newton_solver i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    kns_scoreboard i_scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .open_solutions(open_solutions)
    );

    // sender: bursts of beats separated by random gaps
    task automatic send_orbit(input logic [31:0] anomaly, input logic [15:0] ecc);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {ecc, anomaly};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random_orbit();
        logic [31:0] anomaly;
        logic [15:0] ecc;
        case ($urandom_range(0, 3))
            0: anomaly = $urandom;
            1: anomaly = $urandom_range(0, 32'd1686629714) - 32'd843314857; // within +-pi
            2: anomaly = $urandom_range(0, 4000) - 2000;
            default: anomaly = $urandom_range(0, 32'd3373259428) - 32'd1686629714;
        endcase
        case ($urandom_range(0, 5))
            0: ecc = 16'(16'hFFFF - $urandom_range(0, 300));
            1: ecc = 16'($urandom_range(0, 300));
            default: ecc = 16'($urandom);
        endcase
        send_orbit(anomaly, ecc);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [28:0] value);
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (open_solutions != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [28:0] tol, input logic [6:0] lim, input int n);
        write_reg(kns_pkg::REG_TOLERANCE, tol);
        write_reg(kns_pkg::REG_LIMIT, lim);
        repeat (n) send_random_orbit();
    endtask

    // receiver: changing stall pattern, one long hold-off while the sender keeps offering
    initial begin
        int mode, span;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        repeat (30000) begin
            m_tready <= 1'b1;
            @(posedge aclk);
        end
        m_tready <= 1'b0;
        repeat (3000) @(posedge aclk);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(50, 2000);
            repeat (span) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= $urandom_range(0, 5) == 0;
                    default: m_tready <= $urandom_range(0, 9) != 0;
                endcase
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT && !stimulus_done) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int drain;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: field extremes, near-parabolic orbits, zero inputs
        send_orbit(32'h0000_0000, 16'h0000);
        send_orbit(32'h0000_0000, 16'hFFFF);
        send_orbit(32'h7FFF_FFFF, 16'h0000);
        send_orbit(32'h8000_0000, 16'h0000);
        send_orbit(32'h7FFF_FFFF, 16'hFFFF);
        send_orbit(32'h8000_0000, 16'hFFFF);
        send_orbit(32'h0000_0001, 16'hFFFF);
        send_orbit(32'hFFFF_FFFF, 16'hFFFF);
        send_orbit(32'h3243_F6A9, 16'h8000);
        send_orbit(32'hCDBC_0957, 16'h8000);
        send_orbit(32'h1921_FB54, 16'hFFFF);
        send_orbit(32'h6487_ED51, 16'h4000);
        send_orbit(32'h5555_5555, 16'hAAAA);
        send_orbit(32'hAAAA_AAAA, 16'h5555);
        send_orbit(32'h0010_0000, 16'hFFF0);
        send_orbit(32'hFFF0_0000, 16'h0001);
        repeat (400) send_random_orbit();
        run_phase(29'd0, 7'd64, 20);            // tolerance never met
        run_phase(29'd268435456, 7'd1, 300);    // tolerance 1.0 (2^28), single step
        run_phase(29'd1, 7'd127, 30);           // limit beyond cap
        run_phase(29'd26844, 7'd0, 20);         // no step at all
        send_orbit(32'h7FFF_FFFF, 16'hFFFF);
        run_phase(29'h1FFF_FFFF, 7'd3, 100);
        repeat (4) run_phase(29'($urandom_range(1, 1 << 20)), 7'($urandom_range(1, 16)), 150);
        s_tvalid <= 1'b0;
        drain = 0;
        @(posedge aclk);
        while (open_solutions != 0 && drain < STALL_LIMIT) begin
            drain++;
            @(posedge aclk);
        end
        stimulus_done = 1;
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && open_solutions == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
